// ===== design/wef_pkg.sv =====
// wef_pkg: shared types and constants of the windowed ema filter
// used by the cell, the update unit, the top level and the checker
`default_nettype none

package wef_pkg;

  localparam int WINDOW_DEFAULT = 10;
  localparam int SAMPLE_W       = 16;
  localparam int ALPHA_W        = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ALPHA_W-1:0]         alpha_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control of the average register
  typedef struct packed {
    logic seed;
    logic step;
  } upd_ctrl_t;

endpackage

`default_nettype wire

// ===== design/wef_cell.sv =====
// wef_cell: one sample cell of the window delay line
// depends on wef_pkg for the sample type
`default_nettype none

module wef_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire wef_pkg::sample_t  d,
  output wef_pkg::sample_t       q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== design/wef_update.sv =====
// wef_update: average register and one ema update step
// avg + floor(alpha * (x - avg) / 2^16), clamped; depends on wef_pkg
`default_nettype none

module wef_update (
  input  wire logic                  clk,
  input  wire wef_pkg::upd_ctrl_t    ctrl,
  input  wire wef_pkg::sample_t      seed_value,
  input  wire wef_pkg::sample_t      x,
  input  wire wef_pkg::alpha_t       alpha,
  output wef_pkg::sample_t           next_avg
);

  localparam int SW = wef_pkg::SAMPLE_W;
  localparam int AW = wef_pkg::ALPHA_W;
  localparam int PW = AW + SW + 2;

  wef_pkg::sample_t     avg;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [SW+1:0] delta;
  logic signed [SW+1:0] sum;

  // alpha*x + (1-alpha)*avg rewritten as avg*2^16 + alpha*(x-avg)
  always_comb begin
    diff  = $signed({x[SW-1], x}) - $signed({avg[SW-1], avg});
    prod  = $signed({1'b0, alpha}) * diff;
    delta = prod[PW-1:AW];
    sum   = $signed({{2{avg[SW-1]}}, avg}) + delta;
    if (sum > $signed({2'b00, 1'b0, {(SW-1){1'b1}}})) begin
      next_avg = {1'b0, {(SW-1){1'b1}}};
    end else if (sum < $signed({2'b11, 1'b1, {(SW-1){1'b0}}})) begin
      next_avg = {1'b1, {(SW-1){1'b0}}};
    end else begin
      next_avg = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.seed) begin
      avg <= seed_value;
    end else if (ctrl.step) begin
      avg <= next_avg;
    end
  end

endmodule

`default_nettype wire

// ===== design/windowed_ema_filter.sv =====
// windowed_ema_filter: ema over the last WINDOW samples, seeded with the oldest
// once full, every accepted sample starts a run that ends in its average
// no new sample is taken until the run is over; the window rotates past one update unit
// while the window fills, a sample is taken without a stall and yields no average
// reset (rst, synchronous): empties the window, idles the sequencer, drops the output,
// and loads smoothing_factor with 2/(WINDOW+1) in Q0.16
`default_nettype none

module windowed_ema_filter #(
  parameter int WINDOW = wef_pkg::WINDOW_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output      logic             sample_stall,
  input  wire wef_pkg::sample_t sample,
  output      logic             average_valid,
  input  wire logic             average_stall,
  output wef_pkg::sample_t      average,
  input  wire logic             cfg_we,
  input  wire wef_pkg::alpha_t  cfg_data
);

  localparam int CntW       = $clog2(WINDOW);
  localparam int FillW      = $clog2(WINDOW + 1);
  localparam int AlphaReset = (131072 + (WINDOW + 1) / 2) / (WINDOW + 1);

  wef_pkg::state_t    state, state_next;
  wef_pkg::upd_ctrl_t upd_ctrl;
  wef_pkg::alpha_t    smoothing_factor;
  wef_pkg::sample_t   cell_d [WINDOW];
  wef_pkg::sample_t   cell_q [WINDOW];
  wef_pkg::sample_t   next_avg;

  logic [CntW-1:0]  cnt;
  logic [FillW-1:0] fill_count;
  logic             accept;
  logic             last;
  logic             out_free;
  logic             rotate;
  logic             fill_full;
  logic             full_after;

  assign accept     = sample_valid && !sample_stall;
  assign last       = (cnt == CntW'(WINDOW - 1));
  assign out_free   = !average_valid || !average_stall;
  assign fill_full  = (fill_count == FillW'(WINDOW));
  assign full_after = fill_full || (fill_count == FillW'(WINDOW - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wef_pkg::ST_IDLE: begin
        if (accept && full_after) begin
          state_next = wef_pkg::ST_RUN;
        end
      end
      wef_pkg::ST_RUN: begin
        if (last && out_free) begin
          state_next = wef_pkg::ST_IDLE;
        end
      end
      default: state_next = wef_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample_stall = 1'b0;
    rotate       = 1'b0;
    case (state)
      wef_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
      end
      wef_pkg::ST_RUN: begin
        sample_stall = 1'b1;
        // hold the last step until the output slot is free
        rotate       = !last || out_free;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

  assign upd_ctrl = '{seed: accept, step: rotate};

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= wef_pkg::ST_IDLE;
      cnt              <= '0;
      fill_count       <= '0;
      average_valid    <= 1'b0;
      smoothing_factor <= AlphaReset[wef_pkg::ALPHA_W-1:0];
    end else begin
      state <= state_next;
      if (cfg_we) begin
        smoothing_factor <= cfg_data;
      end
      if (accept && !fill_full) begin
        fill_count <= fill_count + 1'b1;
      end
      if (accept) begin
        cnt <= '0;
      end else if (rotate) begin
        cnt <= last ? '0 : cnt + 1'b1;
      end
      if (rotate && last) begin
        average_valid <= 1'b1;
      end else if (!average_stall) begin
        average_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rotate && last) begin
      average <= next_avg;
    end
  end

  // each cell takes its neighbor: new sample enters at the tail,
  // during a run the head wraps around to the tail
  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      cell_d[k] = cell_q[k + 1];
    end
    cell_d[WINDOW - 1] = accept ? sample : cell_q[0];
  end

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    wef_cell u_cell (
      .clk (clk),
      .en  (accept || rotate),
      .d   (cell_d[k]),
      .q   (cell_q[k])
    );
  end

  // seed with the oldest sample of the new window
  wef_update u_update (
    .clk        (clk),
    .ctrl       (upd_ctrl),
    .seed_value (cell_q[1]),
    .x          (cell_q[0]),
    .alpha      (smoothing_factor),
    .next_avg   (next_avg)
  );

endmodule

`default_nettype wire

// ===== design/wef_checker.sv =====
// wef_checker: port-level checks of windowed_ema_filter, bound to the top level
// depends on wef_pkg for the payload types
`default_nettype none

module wef_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              sample_valid,
  input wire logic              sample_stall,
  input wire wef_pkg::sample_t  sample,
  input wire logic              average_valid,
  input wire logic              average_stall,
  input wire wef_pkg::sample_t  average
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    average_valid && average_stall |=> average_valid && $stable(average))
    else $error("stalled average changed or dropped");

  // a result only appears after a run, during which requests are stalled
  a_rose_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(average_valid) && !$past(rst) |-> $past(sample_stall))
    else $error("average appeared without a run");

  // the end of a run always leaves a result waiting
  a_run_end_result: assert property (@(posedge clk) disable iff (rst)
    $fell(sample_stall) && !$past(rst) |-> average_valid)
    else $error("run ended without a result");

  // a run only starts on an accepted request
  a_stall_after_request: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) && !$past(rst) |-> $past(sample_valid))
    else $error("input stalled without a request");

  // a stalled request holds its sample
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("stalled sample changed or dropped");

endmodule

bind windowed_ema_filter wef_checker u_wef_checker (.*);

`default_nettype wire

// ===== verif/windowed_ema_filter_test.sv =====
// windowed_ema_filter_test: self-checking bench for the windowed ema filter
// predicts every average from its own copy of the window and alpha, checks in order
// depends on wef_pkg and windowed_ema_filter
`timescale 1ns / 100ps

module windowed_ema_filter_test;

  localparam int WINDOW = wef_pkg::WINDOW_DEFAULT;
  localparam int unsigned ALPHA_DEFAULT = (131072 + (WINDOW + 1) / 2) / (WINDOW + 1);
  localparam int DRAIN_CYCLES = WINDOW + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 17;
  localparam int PHASE_ITEMS = 150;
  localparam wef_pkg::sample_t SAMPLE_MAX = 16'sh7fff;
  localparam wef_pkg::sample_t SAMPLE_MIN = 16'sh8000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  wef_pkg::sample_t sample = '0;
  logic average_valid;
  logic average_stall = 1'b1;
  wef_pkg::sample_t average;
  logic cfg_we = 1'b0;
  wef_pkg::alpha_t cfg_data = '0;

  // predictor state
  wef_pkg::sample_t window_hist[WINDOW];
  int fill_level;
  wef_pkg::alpha_t alpha_now;
  wef_pkg::sample_t pending_averages[$];
  wef_pkg::sample_t last_sample;

  int mismatch_count;
  int cycle_count;
  int hold_cycles;
  bit sender_steady;
  bit receiver_steady;

  windowed_ema_filter #(.WINDOW(WINDOW)) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .average_valid(average_valid),
    .average_stall(average_stall),
    .average(average),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // one update: floor((a*x + (1-a)*avg) / 2^16), clamped to the sample range
  function automatic wef_pkg::sample_t ema_mix(wef_pkg::sample_t avg, wef_pkg::sample_t x,
                                               wef_pkg::alpha_t a);
    longint signed acc;
    longint signed q;
    acc = longint'(a) * longint'(x) + (longint'(65536) - longint'(a)) * longint'(avg);
    q = acc >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return wef_pkg::sample_t'(q[15:0]);
  endfunction

  task automatic record_sample(input wef_pkg::sample_t x);
    wef_pkg::sample_t avg;
    for (int k = 0; k < WINDOW - 1; k++) window_hist[k] = window_hist[k + 1];
    window_hist[WINDOW - 1] = x;
    if (fill_level < WINDOW) fill_level++;
    if (fill_level == WINDOW) begin
      avg = window_hist[0];
      for (int k = 0; k < WINDOW; k++) avg = ema_mix(avg, window_hist[k], alpha_now);
      pending_averages.push_back(avg);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(input wef_pkg::sample_t x);
    while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= x;
    do @(posedge clk); while (sample_stall);
    record_sample(x);
    last_sample = x;
    @(negedge clk);
  endtask

  // sender pauses until every outstanding average has come back
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_alpha(input wef_pkg::alpha_t a);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= a;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= ~a;
    alpha_now = a;
    @(negedge clk);
  endtask

  function automatic wef_pkg::sample_t pick_sample();
    int mode;
    mode = $urandom_range(99);
    if (mode < 60) return wef_pkg::sample_t'($urandom_range(65535));
    if (mode < 75) begin
      case ($urandom_range(3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return wef_pkg::sample_t'(0);
        default: return wef_pkg::sample_t'(-1);
      endcase
    end
    if (mode < 90) return wef_pkg::sample_t'(int'($urandom_range(128)) - 64);
    return last_sample;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  // window fill with extremes: nothing until the tenth sample
  task automatic test_window_fill();
    wef_pkg::sample_t vals[WINDOW];
    vals = '{SAMPLE_MAX, SAMPLE_MIN, 16'sh0000, -16'sh0001, 16'sh0001,
             SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 16'sh5555};
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
  endtask

  // alpha zero holds the oldest sample, full alpha tracks the input
  task automatic test_alpha_extremes();
    wef_pkg::alpha_t settings[3];
    settings = '{16'h0000, 16'hffff, 16'h0001};
    foreach (settings[s]) begin
      write_alpha(settings[s]);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(16'shaaaa);
      send_sample(-16'sh0001);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    wef_pkg::alpha_t a;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: a = wef_pkg::alpha_t'($urandom_range(65535));
        1: a = 16'h0000;
        2: a = 16'hffff;
        3: a = 16'h8000;
        4: a = wef_pkg::alpha_t'(ALPHA_DEFAULT);
        5: a = wef_pkg::alpha_t'($urandom_range(1, 4096));
        default: a = wef_pkg::alpha_t'($urandom_range(61440, 65535));
      endcase
      write_alpha(a);
      // one phase runs with neither side idling
      sender_steady = (p == 3);
      receiver_steady = (p == 3);
      send_random(PHASE_ITEMS);
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    wait_drained();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_holdoff();
    hold_cycles = 400;
    send_random(40);
    wait_drained();
  endtask

  task automatic test_pause_resume();
    write_alpha(wef_pkg::alpha_t'($urandom_range(65535)));
    send_random(60);
    wait_drained();
    send_random(60);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      average_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (receiver_steady) begin
      average_stall <= 1'b0;
    end else begin
      average_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    wef_pkg::sample_t want;
    if (!rst && average_valid && !average_stall) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("average %0d with no request outstanding", average));
      end else begin
        want = pending_averages.pop_front();
        if (average !== want)
          report_mismatch($sformatf("average got %0d want %0d", average, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (window_hist[k]) window_hist[k] = '0;
    fill_level = 0;
    alpha_now = wef_pkg::alpha_t'(ALPHA_DEFAULT);
    last_sample = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_window_fill();
    test_alpha_extremes();
    test_output_holdoff();
    test_random_phases();
    test_pause_resume();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/wef_pkg.sv
design/wef_cell.sv
design/wef_update.sv
design/windowed_ema_filter.sv
design/wef_checker.sv
verif/windowed_ema_filter_test.sv
